FILE: hw/rtl/etd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_pkg: shared constants, prime list and state type
// Default sizes, the ascending prime list that seeds the prime table, and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
package etd_pkg;

   localparam int DEFAULT_VALUE_BITS  = 20;
   localparam int DEFAULT_PRIME_LIMIT = 1100;
   localparam int DEFAULT_PRIME_COUNT = 184;

   localparam int PRIME_BITS      = 11;
   localparam int PRIME_ROM_DEPTH = 184;

   // all primes up to 1100, ascending
   localparam logic [PRIME_BITS-1:0] PRIME_ROM [PRIME_ROM_DEPTH] = '{
      11'd2,    11'd3,    11'd5,    11'd7,    11'd11,   11'd13,   11'd17,   11'd19,
      11'd23,   11'd29,   11'd31,   11'd37,   11'd41,   11'd43,   11'd47,   11'd53,
      11'd59,   11'd61,   11'd67,   11'd71,   11'd73,   11'd79,   11'd83,   11'd89,
      11'd97,   11'd101,  11'd103,  11'd107,  11'd109,  11'd113,  11'd127,  11'd131,
      11'd137,  11'd139,  11'd149,  11'd151,  11'd157,  11'd163,  11'd167,  11'd173,
      11'd179,  11'd181,  11'd191,  11'd193,  11'd197,  11'd199,  11'd211,  11'd223,
      11'd227,  11'd229,  11'd233,  11'd239,  11'd241,  11'd251,  11'd257,  11'd263,
      11'd269,  11'd271,  11'd277,  11'd281,  11'd283,  11'd293,  11'd307,  11'd311,
      11'd313,  11'd317,  11'd331,  11'd337,  11'd347,  11'd349,  11'd353,  11'd359,
      11'd367,  11'd373,  11'd379,  11'd383,  11'd389,  11'd397,  11'd401,  11'd409,
      11'd419,  11'd421,  11'd431,  11'd433,  11'd439,  11'd443,  11'd449,  11'd457,
      11'd461,  11'd463,  11'd467,  11'd479,  11'd487,  11'd491,  11'd499,  11'd503,
      11'd509,  11'd521,  11'd523,  11'd541,  11'd547,  11'd557,  11'd563,  11'd569,
      11'd571,  11'd577,  11'd587,  11'd593,  11'd599,  11'd601,  11'd607,  11'd613,
      11'd617,  11'd619,  11'd631,  11'd641,  11'd643,  11'd647,  11'd653,  11'd659,
      11'd661,  11'd673,  11'd677,  11'd683,  11'd691,  11'd701,  11'd709,  11'd719,
      11'd727,  11'd733,  11'd739,  11'd743,  11'd751,  11'd757,  11'd761,  11'd769,
      11'd773,  11'd787,  11'd797,  11'd809,  11'd811,  11'd821,  11'd823,  11'd827,
      11'd829,  11'd839,  11'd853,  11'd857,  11'd859,  11'd863,  11'd877,  11'd881,
      11'd883,  11'd887,  11'd907,  11'd911,  11'd919,  11'd929,  11'd937,  11'd941,
      11'd947,  11'd953,  11'd967,  11'd971,  11'd977,  11'd983,  11'd991,  11'd997,
      11'd1009, 11'd1013, 11'd1019, 11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049,
      11'd1051, 11'd1061, 11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097
   };

   // number of table entries actually filled for a given limit and capacity
   function automatic int prime_valid_count(int limit, int count);
      int n;
      n = 0;
      for (int i = 0; i < PRIME_ROM_DEPTH; i++) begin
         if ((int'(PRIME_ROM[i]) <= limit) && (n < count)) begin
            n++;
         end
      end
      return n;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DIV_REST,
      ST_DIV_PHI,
      ST_MUL_PHI,
      ST_NEXT,
      ST_FINAL,
      ST_DONE
   } etd_state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/etd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_if: request and response channels
// Valid/ready channels carrying the input number and the totient result.
// ----------------------------------------------------------------------------
interface etd_req_if #(
   parameter int WIDTH = etd_pkg::DEFAULT_VALUE_BITS
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] number_in;

   modport source (output valid, output number_in, input ready);
   modport sink   (input valid, input number_in, output ready);
endinterface

interface etd_rsp_if #(
   parameter int WIDTH = etd_pkg::DEFAULT_VALUE_BITS
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] totient_out;

   modport source (output valid, output totient_out, input ready);
   modport sink   (input valid, input totient_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/etd_prime_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_prime_mem: prime table memory
// Synchronous simple dual-port table, refilled from the prime list after
// reset, one entry a cycle; read data registered.
// ----------------------------------------------------------------------------
module etd_prime_mem #(
   parameter  int PRIME_COUNT = etd_pkg::DEFAULT_PRIME_COUNT,
   parameter  int PRIME_LIMIT = etd_pkg::DEFAULT_PRIME_LIMIT,
   localparam int ADDR_BITS   = $clog2(PRIME_COUNT)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ADDR_BITS-1:0]          rd_addr,
   output logic      [etd_pkg::PRIME_BITS-1:0] rd_data,
   output logic                               fill_done
);
   import etd_pkg::*;

   localparam int PRIME_VALID = prime_valid_count(PRIME_LIMIT, PRIME_COUNT);

   logic [PRIME_BITS-1:0] mem [PRIME_COUNT];
   logic [PRIME_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]  fill_addr_ff, fill_addr_in;
   logic                  fill_done_ff, fill_done_in;

   // advance the fill pointer until the last valid prime is written
   always_comb begin
      fill_addr_in = fill_addr_ff;
      fill_done_in = fill_done_ff;
      if (!fill_done_ff) begin
         if (fill_addr_ff == ADDR_BITS'(PRIME_VALID - 1)) begin
            fill_done_in = 1'b1;
         end else begin
            fill_addr_in = fill_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_addr_ff <= '0;
         fill_done_ff <= 1'b0;
      end else begin
         fill_addr_ff <= fill_addr_in;
         fill_done_ff <= fill_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!fill_done_ff) begin
         mem[fill_addr_ff] <= PRIME_ROM[fill_addr_ff];
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data   = rd_data_ff;
   assign fill_done = fill_done_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/etd_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_divider: serial restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle; results held
// until the next start.
// ----------------------------------------------------------------------------
module etd_divider #(
   parameter int WIDTH = etd_pkg::DEFAULT_VALUE_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder,
   output logic                  done
);
   localparam int CNT_BITS = $clog2(WIDTH);

   logic [WIDTH-1:0]    quo_ff, quo_in;
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [WIDTH:0]      shifted;
   logic [WIDTH:0]      diff;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // subtract where it fits, shift in the quotient bit
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         rem_in = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/euler_totient_trial_division.sv
`default_nettype none
// Timing: an input of 0 or 1 needs no division; otherwise the serial divider runs once
//   per prime tried, once per further division by a prime factor and once per
//   scaling of phi, and so sets the time an item takes.
// Throughput: one item at a time; the next item is taken while the result waits.
// Reset: synchronous; the prime table is then refilled, one entry a cycle,
//   and no item is accepted until it is full.
// ----------------------------------------------------------------------------
// euler_totient_trial_division: Euler totient by trial division
// Walks the prime table until p*p exceeds the unfactored rest or the table
// ends, divides each prime factor out and scales phi by (p-1)/p; a leftover
// rest above one is a final prime factor.
// ----------------------------------------------------------------------------
module euler_totient_trial_division #(
   parameter int VALUE_BITS  = etd_pkg::DEFAULT_VALUE_BITS,
   parameter int PRIME_LIMIT = etd_pkg::DEFAULT_PRIME_LIMIT,
   parameter int PRIME_COUNT = etd_pkg::DEFAULT_PRIME_COUNT
) (
   input wire logic  clock,
   input wire logic  reset,
   etd_req_if.sink   req_if,
   etd_rsp_if.source rsp_if
);
   import etd_pkg::*;

   localparam int PRIME_VALID = prime_valid_count(PRIME_LIMIT, PRIME_COUNT);
   localparam int ADDR_BITS   = $clog2(PRIME_COUNT);
   localparam int SQ_BITS     = 2 * PRIME_BITS;
   localparam int PROD_BITS   = 2 * VALUE_BITS;

   etd_state_type state_ff, state_in;

   logic [ADDR_BITS-1:0]  k_ff, k_in;          // table index of the prime on trial
   logic [VALUE_BITS-1:0] rest_ff, rest_in;    // part of n not yet factored
   logic [VALUE_BITS-1:0] phi_ff, phi_in;      // running totient
   logic [VALUE_BITS-1:0] scale_ff, scale_in;  // current prime, or final cofactor
   logic                  hit_ff, hit_in;      // current prime divides n
   logic                  final_ff, final_in;  // scaling by the final cofactor
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [PRIME_BITS-1:0] prime;
   logic                  fill_done;
   logic [SQ_BITS-1:0]    prime_sq;
   logic [PROD_BITS-1:0]  scale_prod;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_divisor;
   logic [VALUE_BITS-1:0] div_quo;
   logic [VALUE_BITS-1:0] div_rem;
   logic                  div_done;

   etd_prime_mem #(
      .PRIME_COUNT (PRIME_COUNT),
      .PRIME_LIMIT (PRIME_LIMIT)
   ) u_prime_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (k_ff),
      .rd_data   (prime),
      .fill_done (fill_done)
   );

   etd_divider #(
      .WIDTH (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   assign prime_sq   = SQ_BITS'(prime) * SQ_BITS'(prime);
   // phi / s * (s - 1), the quotient coming straight from the divider
   assign scale_prod = PROD_BITS'(div_quo) * PROD_BITS'(scale_ff - VALUE_BITS'(1));

   // take a new item only when the sequencer is free and the table is full
   assign req_if.ready = (state_ff == ST_IDLE) && fill_done;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rest_in      = rest_ff;
      phi_in       = phi_ff;
      scale_in     = scale_ff;
      hit_in       = hit_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = rest_ff;
      div_divisor  = scale_ff;

      // drop the result once the sink has taken it
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid && fill_done) begin
               rest_in  = req_if.number_in;
               phi_in   = req_if.number_in;
               k_in     = '0;
               final_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // table read in flight
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (prime_sq > SQ_BITS'(rest_ff)) begin
               state_in = ST_FINAL;
            end else begin
               // p*p <= rest, so p fits the value width here
               scale_in     = VALUE_BITS'(prime);
               hit_in       = 1'b0;
               div_start    = 1'b1;
               div_dividend = rest_ff;
               div_divisor  = VALUE_BITS'(prime);
               state_in     = ST_DIV_REST;
            end
         end
         ST_DIV_REST: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  // divide the prime out again
                  rest_in      = div_quo;
                  hit_in       = 1'b1;
                  div_start    = 1'b1;
                  div_dividend = div_quo;
                  div_divisor  = scale_ff;
               end else if (hit_ff) begin
                  div_start    = 1'b1;
                  div_dividend = phi_ff;
                  div_divisor  = scale_ff;
                  state_in     = ST_DIV_PHI;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_DIV_PHI: begin
            if (div_done) begin
               state_in = ST_MUL_PHI;
            end
         end
         ST_MUL_PHI: begin
            phi_in   = scale_prod[VALUE_BITS-1:0];
            state_in = final_ff ? ST_DONE : ST_NEXT;
         end
         ST_NEXT: begin
            if (k_ff == ADDR_BITS'(PRIME_VALID - 1)) begin
               state_in = ST_FINAL;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_FINAL: begin
            // a cofactor above one is a prime of its own
            if (rest_ff > VALUE_BITS'(1)) begin
               scale_in     = rest_ff;
               final_in     = 1'b1;
               div_start    = 1'b1;
               div_dividend = phi_ff;
               div_divisor  = rest_ff;
               state_in     = ST_DIV_PHI;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = phi_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         hit_ff       <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         hit_ff       <= hit_in;
         final_ff     <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff     <= rest_in;
      phi_ff      <= phi_in;
      scale_ff    <= scale_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.totient_out = rsp_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/etd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_checker: port-level checks
// Tracks items in flight and checks the result channel against the inputs.
// ----------------------------------------------------------------------------
module etd_checker #(
   parameter int WIDTH = etd_pkg::DEFAULT_VALUE_BITS
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [WIDTH-1:0] req_number,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [WIDTH-1:0] rsp_totient
);
   logic [1:0]       pending_ff, pending_in;
   logic [WIDTH-1:0] last_num_ff, last_num_in;
   logic             req_acc;
   logic             rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pending_in  = pending_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
      last_num_in = req_acc ? req_number : last_num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      last_num_ff <= last_num_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_totient))
      else $error("result changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result offered with no item outstanding");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pending_ff == 2'd1) |-> rsp_totient <= last_num_ff)
      else $error("totient exceeds its input");

   a_small: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pending_ff == 2'd1) && (last_num_ff <= WIDTH'(1))
      |-> rsp_totient == last_num_ff)
      else $error("zero or one input gave a wrong totient");

endmodule

bind euler_totient_trial_division etd_checker #(
   .WIDTH (VALUE_BITS)
) u_etd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_number  (req_if.number_in),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_totient (rsp_if.totient_out)
);
`default_nettype wire

FILE: tb/euler_totient_trial_division_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient_trial_division_tb: self-checking bench for the totient block
// Feeds integers over the request channel and compares every totient on the
// response channel with a local trial-division calculation. It covers the edge
// values, prime powers, products of primes and plain random numbers. Both
// channels stall at random except in two stretches with idling off, one the last.
// ----------------------------------------------------------------------------
module euler_totient_trial_division_tb;

   import etd_pkg::*;

   localparam int VALUE_BITS  = DEFAULT_VALUE_BITS;
   localparam int PRIME_LIMIT = DEFAULT_PRIME_LIMIT;
   localparam int PRIME_COUNT = DEFAULT_PRIME_COUNT;
   localparam longint unsigned MAX_VALUE = (64'd1 << VALUE_BITS) - 64'd1;

   // Worst item: every prime up to 1021 tried, plus divisions and scalings.
   // The limit takes several times that item's time, plus reset fill.
   localparam int STALL_LIMIT   = 20000;
   // Cycles to keep watching for stray results once nothing is pending
   localparam int SETTLE_CYCLES = 4800;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      value_type number;
      value_type totient;
   } totient_case_type;

   logic clock;
   logic reset;

   etd_req_if #(.WIDTH(VALUE_BITS)) req_ch ();
   etd_rsp_if #(.WIDTH(VALUE_BITS)) rsp_ch ();

   euler_totient_trial_division #(
      .VALUE_BITS  (VALUE_BITS),
      .PRIME_LIMIT (PRIME_LIMIT),
      .PRIME_COUNT (PRIME_COUNT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Local prime list, built by a sieve; the block's own table should match
   int unsigned      prime_list[$];
   totient_case_type totient_pending[$];
   int               mismatch_count;
   int               quiet_cycles;
   bit               sender_idling;
   bit               receiver_idling;
   int               receiver_hold;

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   task automatic build_prime_list();
      bit composite [PRIME_LIMIT+1];
      prime_list.delete();
      for (int i = 0; i <= PRIME_LIMIT; i++) composite[i] = 1'b0;
      for (int i = 2; i <= PRIME_LIMIT; i++) begin
         if (!composite[i]) begin
            // cap the list at the table capacity
            if (prime_list.size() < PRIME_COUNT) prime_list = {prime_list, i};
            for (int j = i * i; j <= PRIME_LIMIT; j += i) composite[j] = 1'b1;
         end
      end
   endtask

   // Trial division over the prime list; a cofactor left above one is a prime
   function automatic value_type predict_totient(input value_type number);
      longint unsigned rest;
      longint unsigned phi;
      longint unsigned p;
      rest = number;
      phi  = number;
      foreach (prime_list[k]) begin
         p = prime_list[k];
         if (p * p > rest) break;
         if (rest % p == 0) begin
            while (rest % p == 0) rest = rest / p;
            phi = (phi / p) * (p - 1);
         end
      end
      if (rest > 1) phi = (phi / rest) * (rest - 1);
      return value_type'(phi);
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard: queue a prediction per accepted number, check each totient
   // -------------------------------------------------------------------------

   always @(posedge clock) begin
      totient_case_type head;
      totient_case_type entry;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            entry.number    = req_ch.number_in;
            entry.totient   = predict_totient(req_ch.number_in);
            totient_pending = {totient_pending, entry};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (totient_pending.size() == 0) begin
               $display("%0t: unexpected totient %0d with nothing pending",
                        $time, rsp_ch.totient_out);
               mismatch_count++;
            end else begin
               head = totient_pending.pop_front();
               if (rsp_ch.totient_out !== head.totient) begin
                  $display("%0t: totient mismatch for n=%0d: expected %0d, actual %0d",
                           $time, head.number, head.totient, rsp_ch.totient_out);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: drop ready in bursts of random length while idling is on
   always @(posedge clock) begin
      if (receiver_idling && receiver_hold > 0) begin
         receiver_hold  <= receiver_hold - 1;
         rsp_ch.ready   <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
         receiver_hold  <= $urandom_range(0, 6);
         rsp_ch.ready   <= 1'b0;
      end else begin
         rsp_ch.ready   <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Present one number and hold it until accepted. Valid stays high on
   // return so that a following number can go straight out.
   task automatic send_number(input value_type number);
      if (sender_idling && $urandom_range(0, 2) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.number_in <= number;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid and hold until every queued totient has come back; wait for a
   // clock edge first so the last accepted number is already queued
   task automatic wait_for_totients();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (totient_pending.size() != 0) @(posedge clock);
   endtask

   function automatic int unsigned pick_prime(input int lowest_index);
      return prime_list[$urandom_range(lowest_index, prime_list.size() - 1)];
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Zero, unit, tiny values, field extremes and the slowest cases
   task automatic test_edge_values();
      value_type directed[$];
      directed = '{
         value_type'(0), value_type'(1), value_type'(2), value_type'(3), value_type'(4),
         value_type'(6), value_type'(9),
         value_type'(MAX_VALUE),       // all ones: 3 * 5^2 * 11 * 31 * 41
         value_type'(1048573),         // largest prime in range: longest table walk
         value_type'(1042441),         // 1021 squared
         value_type'(1048351),         // 1009 * 1039, two primes near the root
         value_type'(524288),          // 2^19
         value_type'(510510),          // product of the first seven primes
         value_type'(1097),            // last table prime, above its own root
         value_type'(999983),
         value_type'(1100),
         value_type'(20'h55555),
         value_type'(20'hAAAAA),
         value_type'(531441),          // 3^12
         value_type'(1046529)          // 1023^2, composite square
      };
      foreach (directed[i]) send_number(directed[i]);
      wait_for_totients();
   endtask

   // Well-formed factorisations with random content, mixed with noise
   task automatic test_factored_numbers(input int count);
      longint unsigned acc;
      longint unsigned p;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 4))
            0: acc = $urandom_range(0, int'(MAX_VALUE));
            1: acc = $urandom_range(0, 200);
            2: begin
               // prime power
               p   = pick_prime(0);
               acc = p;
               while (acc * p <= MAX_VALUE && $urandom_range(0, 3) != 0) acc = acc * p;
            end
            3: begin
               // product of a few primes, repeats allowed
               acc = 1;
               repeat ($urandom_range(1, 5)) begin
                  p = pick_prime(0);
                  if (acc * p <= MAX_VALUE) acc = acc * p;
               end
            end
            default: begin
               // large prime times a small cofactor, long table walk
               acc = pick_prime(150);
               p   = $urandom_range(1, 950);
               if (acc * p <= MAX_VALUE) acc = acc * p;
            end
         endcase
         send_number(value_type'(acc));
      end
   endtask

   // Pause the sender until the block has returned everything, then resume
   task automatic test_drain_pause();
      repeat (4) send_number(value_type'($urandom));
      wait_for_totients();
      repeat (4) send_number(value_type'($urandom_range(0, 1000)));
      wait_for_totients();
   endtask

   // Plain random numbers over the whole field
   task automatic test_random_numbers(input int count);
      repeat (count) send_number(value_type'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // Run
   // -------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.number_in = '0;
      rsp_ch.ready     = 1'b0;
      sender_idling    = 1'b1;
      receiver_idling  = 1'b1;
      receiver_hold    = 0;
      quiet_cycles     = 0;
      mismatch_count   = 0;
      build_prime_list();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_edge_values();
      test_factored_numbers(60);
      wait_for_totients();
      test_drain_pause();

      // stretch with no idling on either side, then idling again
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      test_factored_numbers(15);
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      test_random_numbers(25);
      wait_for_totients();

      // last part: no idling at all
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      test_factored_numbers(20);
      wait_for_totients();

      // watch for stray results
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && totient_pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
